### sv/rc5_pkg.sv
// ----------------------------------------------------------------------------
// rc5_pkg
// Shared widths, reset values and register indexes for the RC5 edge decoder.
// ----------------------------------------------------------------------------
package rc5_pkg;

   localparam int unsigned TimeWidth  = 8;
   localparam int unsigned FrameWidth = 14;
   localparam int unsigned PosWidth   = 4;
   localparam int unsigned CsrAddrW   = 2;

   localparam int unsigned ReqDataW   = 16;
   localparam int unsigned RspDataW   = 16;

   localparam logic [PosWidth-1:0] PosStartHi = 4'd13;
   localparam logic [PosWidth-1:0] PosStartLo = 4'd12;
   localparam logic [PosWidth-1:0] PosCheckLo = 4'd11;

   localparam logic [TimeWidth-1:0] HalfMinRst = 8'd5;
   localparam logic [TimeWidth-1:0] HalfMaxRst = 8'd9;
   localparam logic [TimeWidth-1:0] TimeoutRst = 8'd10;

   typedef enum logic [CsrAddrW-1:0] {
      CSR_HALF_MIN = 2'd0,
      CSR_HALF_MAX = 2'd1,
      CSR_TIMEOUT  = 2'd2
   } csr_idx_type;

   typedef enum logic {
      OP_PIN  = 1'b0,
      OP_TICK = 1'b1
   } op_type;

endpackage

### sv/rc5_ir_edge_decoder.sv
// ----------------------------------------------------------------------------
// rc5_ir_edge_decoder
// RC5 infrared frame decoder driven by timestamped pin-change and tick events.
// ----------------------------------------------------------------------------
// req channel: one event per transfer. req_tuser is the event kind (0 pin
// change, 1 timer tick); req_tdata carries the pin level and the 8-bit timer
// value. Pin events measure the interval since the last edge against the
// half-bit and double half-bit windows and shift frame bits from 13 down to 0.
// Ticks feed a saturating idle counter that forces a resync on the next edge.
// rsp channel: exactly one result per event, in the cycle after the req
// transfer: a ready pulse for a new, different frame, the delivered code and
// the frame-complete flag.
// Throughput is one event per cycle unless rsp stalls: the whole state
// update is a subtract, the window compares and a bit write between the req port and the state and
// result registers. A single result register sits on the rsp side; req_tready
// drops only while that register is full and rsp_tready is low.
// Reset (synchronous) restores the window registers to 5, 9 and 10, empties
// the result register and puts the decoder back to waiting for a start edge.
// csr writes take effect at the next edge and are expected only while idle.
// ----------------------------------------------------------------------------
module rc5_ir_edge_decoder
   import rc5_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [ReqDataW-1:0]         req_tdata,   // pin_level, timestamp[7:0], zero pad
   input  logic                        req_tuser,   // opcode
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [RspDataW-1:0]         rsp_tdata,   // code_ready, code_value[13:0], frame_valid
   input  logic                        csr_we,
   input  logic [CsrAddrW-1:0]         csr_addr,
   input  logic [TimeWidth-1:0]        csr_wdata
);

   logic [TimeWidth-1:0]  half_min_ff, half_max_ff, timeout_ff;
   logic [TimeWidth-1:0]  last_edge_ff, last_edge_in;
   logic [TimeWidth-1:0]  last_tick_ff, last_tick_in;
   logic [TimeWidth-1:0]  idle_ff, idle_in;
   logic [PosWidth-1:0]   pos_ff, pos_in;
   logic [FrameWidth-1:0] shift_ff, shift_in;
   logic                  wait_ff, wait_in;
   logic                  half_ff, half_in;
   logic                  prev_ff, prev_in;
   logic [FrameWidth-1:0] code_ff, code_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RspDataW-1:0]   rsp_data_ff, rsp_data_in;

   logic                  accept;
   logic                  pin;
   logic [TimeWidth-1:0]  stamp;
   logic [TimeWidth-1:0]  dt;
   logic [TimeWidth:0]    dt_wide, dbl_min, dbl_max, idle_sum;
   logic                  in_half, in_double, rising, last, ready;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign pin        = req_tdata[0];
   assign stamp      = req_tdata[TimeWidth:1];
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign dt        = (req_tuser == OP_TICK) ? stamp - last_tick_ff : stamp - last_edge_ff;
   assign dt_wide   = {1'b0, dt};
   assign dbl_min   = {half_min_ff, 1'b0};
   assign dbl_max   = {half_max_ff, 1'b0};
   assign idle_sum  = {1'b0, idle_ff} + dt_wide;
   assign in_half   = (dt >= half_min_ff) && (dt <= half_max_ff);
   assign in_double = (dt_wide >= dbl_min) && (dt_wide <= dbl_max);
   assign rising    = pin;

   always_comb begin
      last_edge_in = last_edge_ff;
      last_tick_in = last_tick_ff;
      idle_in      = idle_ff;
      pos_in       = pos_ff;
      shift_in     = shift_ff;
      wait_in      = wait_ff;
      half_in      = half_ff;
      prev_in      = prev_ff;
      code_in      = code_ff;
      last         = 1'b0;
      ready        = 1'b0;
      if (req_tuser == OP_TICK) begin
         if (idle_ff < timeout_ff) begin
            idle_in = idle_sum[TimeWidth] ? '1 : idle_sum[TimeWidth-1:0];
         end
         last_tick_in = stamp;
      end else begin
         last_edge_in = stamp;
         if (idle_ff >= timeout_ff) begin
            wait_in = 1'b1;
         end
         idle_in = '0;
         if (wait_in) begin
            if (prev_ff && !pin) begin
               wait_in  = 1'b0;
               half_in  = 1'b1;
               pos_in   = PosStartHi;
               shift_in = '0;
            end
         end else if (prev_ff != pin) begin
            if (half_ff && in_half) begin
               shift_in[pos_ff] = rising;
               if (pos_ff != '0) begin
                  pos_in = pos_ff - 1'b1;
               end else begin
                  last = 1'b1;
               end
               half_in = 1'b0;
            end else if (half_ff && in_double) begin
               shift_in[pos_ff] = rising;
               if (pos_ff != '0) begin
                  pos_in = pos_ff - 1'b1;
                  if (rising && pos_in == '0) begin
                     last = 1'b1;
                  end
               end else begin
                  last = 1'b1;
               end
            end else if (!half_ff && in_half) begin
               half_in = 1'b1;
               if (rising && pos_ff == '0) begin
                  last = 1'b1;
               end
            end else begin
               wait_in = 1'b1;
            end
         end
         prev_in = pin;
         if ((pos_in == PosStartLo && !shift_in[PosStartHi]) ||
             (pos_in == PosCheckLo && !shift_in[PosStartLo])) begin
            wait_in = 1'b1;
         end
         if (pos_in == '0 && last) begin
            if (code_ff != shift_in) begin
               code_in = shift_in;
               ready   = 1'b1;
            end
            wait_in = 1'b1;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {(pos_in == '0), code_in, ready};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         half_min_ff  <= HalfMinRst;
         half_max_ff  <= HalfMaxRst;
         timeout_ff   <= TimeoutRst;
         last_edge_ff <= '0;
         last_tick_ff <= '0;
         idle_ff      <= '0;
         pos_ff       <= PosStartHi;
         shift_ff     <= '0;
         wait_ff      <= 1'b1;
         half_ff      <= 1'b0;
         prev_ff      <= 1'b1;
         code_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_addr)
               CSR_HALF_MIN: half_min_ff <= csr_wdata;
               CSR_HALF_MAX: half_max_ff <= csr_wdata;
               CSR_TIMEOUT:  timeout_ff  <= csr_wdata;
               default: ;
            endcase
         end
         if (accept) begin
            last_edge_ff <= last_edge_in;
            last_tick_ff <= last_tick_in;
            idle_ff      <= idle_in;
            pos_ff       <= pos_in;
            shift_ff     <= shift_in;
            wait_ff      <= wait_in;
            half_ff      <= half_in;
            prev_ff      <= prev_in;
            code_ff      <= code_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

`ifndef SYNTH
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= PosStartHi)
      else $error("bit position out of range");

   a_tick_keeps_frame: assert property (@(posedge clock) disable iff (reset)
      accept && req_tuser == OP_TICK |=> $stable(pos_ff) && $stable(shift_ff) &&
      $stable(code_ff) && !rsp_data_ff[0])
      else $error("tick event changed decoding state");

   a_ready_new_code: assert property (@(posedge clock) disable iff (reset)
      accept && ready |=> code_ff != $past(code_ff) && rsp_data_ff[FrameWidth:1] == code_ff)
      else $error("ready without a new code");

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("transfer without result");
`endif

endmodule
